### sv/i2cmts_pkg.sv
package i2cmts_pkg;

    // Engine state codes
    typedef enum logic [2:0] {
        ST_WAITING = 3'd0,
        ST_READING = 3'd1,
        ST_WRITING = 3'd2,
        ST_ERROR   = 3'd3,
        ST_NACK    = 3'd4
    } t_state;

    // Commands to the byte-level bus engine
    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_ADDR      = 3'd1,
        CMD_DATA      = 3'd2,
        CMD_ACK       = 3'd3,
        CMD_NACK_STOP = 3'd4,
        CMD_STOP      = 3'd5
    } t_cmd;

    // Completion codes
    typedef enum logic [2:0] {
        DONE_NONE     = 3'd0,
        DONE_OK       = 3'd1,
        DONE_ERROR    = 3'd2,
        DONE_NACK     = 3'd3,
        DONE_REJECTED = 3'd4,
        DONE_ACCEPTED = 3'd5
    } t_done;

    // Item modes
    typedef enum logic [2:0] {
        MODE_EVENT    = 3'd0,
        MODE_START_RD = 3'd1,
        MODE_START_WR = 3'd2,
        MODE_TICK     = 3'd3,
        MODE_RESET    = 3'd4
    } t_mode;

    // Configuration register indexes
    typedef enum logic {
        REG_ENABLED = 1'b0,
        REG_TIMEOUT = 1'b1
    } t_reg_idx;

    localparam int unsigned  PADDR_W       = 3;
    localparam int unsigned  PDATA_W       = 32;
    localparam logic [15:0]  TIMEOUT_RESET = 16'd1000;
    localparam logic         RW_READ       = 1'b1;
    localparam logic         RW_WRITE      = 1'b0;

    // Input beat
    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] target_address;
        logic [7:0] transfer_length;
        logic       arb_lost;
        logic       bus_error;
        logic       rx_nack;
        logic       write_ready;
        logic       read_ready;
        logic [7:0] rx_byte_in;
        logic [7:0] tx_byte;
    } t_req;

    // Result beat
    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] bus_byte_out;
        logic       tx_consumed;
        logic       deliver_valid;
        logic [7:0] deliver_byte;
        logic [2:0] completion;
        logic [2:0] engine_state_out;
        logic       write_irq_enable;
    } t_rsp;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic        enabled;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

### sv/i2cmts_if.sv
interface i2cmts_req_if;
    import i2cmts_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cmts_rsp_if;
    import i2cmts_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/i2cmts_cfg.sv
module i2cmts_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmts_pkg::PADDR_W-1:0]   paddr,
    input  logic [i2cmts_pkg::PDATA_W-1:0]   pwdata,
    output logic [i2cmts_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready,
    output i2cmts_pkg::t_cfg                 o_cfg
);
    import i2cmts_pkg::*;

    logic        r_enabled;
    logic [15:0] r_timeout_ticks;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled       <= 1'b0;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLED: r_enabled       <= pwdata[0];
                REG_TIMEOUT: r_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_ENABLED: prdata = {{(PDATA_W-1){1'b0}}, r_enabled};
            REG_TIMEOUT: prdata = {{(PDATA_W-16){1'b0}}, r_timeout_ticks};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = '{enabled: r_enabled, timeout_ticks: r_timeout_ticks};

endmodule

### sv/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer. Each input beat is a bus event, a read or
// write start, a timeout tick or a reset; each produces exactly one result
// beat carrying the bus engine command, any delivered byte, a completion code
// and the engine state after the beat. A beat is registered in the input
// register on acceptance, worked out combinationally and placed in the result
// register, and one beat per cycle is sustained while the consumer takes results;
// while a finished result waits for the consumer the input register still
// takes one more beat, after which the input side stalls. Configuration
// (enable, timeout ticks) must be written over the APB port only while no
// beat is in flight; the sequencer does not enforce this itself.
module i2c_master_transfer_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    i2cmts_req_if.sink                       i_req,
    i2cmts_rsp_if.source                     o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [i2cmts_pkg::PADDR_W-1:0]   paddr,
    input  logic [i2cmts_pkg::PDATA_W-1:0]   pwdata,
    output logic [i2cmts_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready
);
    import i2cmts_pkg::*;

    t_cfg        cfg;

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;

    t_state      r_state, n_state;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_timeout, n_timeout;
    logic        r_wr_on, n_wr_on;

    t_rsp        rsp;
    logic        advance;
    logic        busy;
    logic        any_err;
    logic        is_rd;
    logic [7:0]  bytes_dec;

    i2cmts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: move a beat forward when the result slot frees up
    assign advance     = r_in_valid & (~r_out_valid | o_rsp.ready);
    assign i_req.ready = ~r_in_valid | advance;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= rsp;
        end
    end

    // Sequencer state, updated as each beat is worked out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WAITING;
            r_bytes_left <= 8'd0;
            r_timeout    <= 16'd0;
            r_wr_on      <= 1'b0;
        end else if (advance) begin
            r_state      <= n_state;
            r_bytes_left <= n_bytes_left;
            r_timeout    <= n_timeout;
            r_wr_on      <= n_wr_on;
        end
    end

    assign busy      = (r_state inside {ST_READING, ST_WRITING});
    assign any_err   = r_in.arb_lost | r_in.bus_error | r_in.rx_nack;
    assign is_rd     = (r_in.mode == MODE_START_RD);
    assign bytes_dec = r_bytes_left - 8'd1;

    // Work out one beat
    always_comb begin
        n_state      = r_state;
        n_bytes_left = r_bytes_left;
        n_timeout    = r_timeout;
        n_wr_on      = r_wr_on;
        rsp          = '0;
        rsp.bus_command = CMD_NONE;
        rsp.completion  = DONE_NONE;

        case (r_in.mode)
            MODE_EVENT: begin
                if (any_err) begin
                    // Error flags win: stop and park in error or nack
                    n_wr_on         = 1'b0;
                    rsp.bus_command = CMD_STOP;
                    n_state         = r_in.rx_nack ? ST_NACK : ST_ERROR;
                    if (busy) begin
                        rsp.completion = r_in.rx_nack ? DONE_NACK : DONE_ERROR;
                    end
                end else if (r_in.write_ready) begin
                    if (r_state == ST_WRITING) begin
                        if (r_bytes_left != 8'd0) begin
                            rsp.bus_command  = CMD_DATA;
                            rsp.bus_byte_out = r_in.tx_byte;
                            rsp.tx_consumed  = 1'b1;
                            n_bytes_left     = bytes_dec;
                        end else begin
                            rsp.bus_command = CMD_STOP;
                            rsp.completion  = DONE_OK;
                            n_wr_on         = 1'b0;
                            n_state         = ST_WAITING;
                        end
                    end
                end else if (r_in.read_ready) begin
                    if (r_state == ST_READING && r_bytes_left != 8'd0) begin
                        rsp.deliver_valid = 1'b1;
                        rsp.deliver_byte  = r_in.rx_byte_in;
                        n_bytes_left      = bytes_dec;
                        if (bytes_dec != 8'd0) begin
                            rsp.bus_command = CMD_ACK;
                        end else begin
                            rsp.bus_command = CMD_NACK_STOP;
                            rsp.completion  = DONE_OK;
                            n_state         = ST_WAITING;
                        end
                    end
                end
            end
            MODE_START_RD, MODE_START_WR: begin
                if (!cfg.enabled || (is_rd && r_in.transfer_length == 8'd0) || busy) begin
                    rsp.completion = DONE_REJECTED;
                end else begin
                    n_bytes_left    = r_in.transfer_length;
                    n_timeout       = cfg.timeout_ticks;
                    rsp.bus_command = CMD_ADDR;
                    rsp.completion  = DONE_ACCEPTED;
                    if (is_rd) begin
                        n_state          = ST_READING;
                        rsp.bus_byte_out = {r_in.target_address, RW_READ};
                    end else begin
                        n_state          = ST_WRITING;
                        rsp.bus_byte_out = {r_in.target_address, RW_WRITE};
                        n_wr_on          = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                // Count down the transfer timeout
                if (busy) begin
                    if (r_timeout <= 16'd1) begin
                        n_timeout      = 16'd0;
                        n_state        = ST_ERROR;
                        rsp.completion = DONE_ERROR;
                    end else begin
                        n_timeout = r_timeout - 16'd1;
                    end
                end
            end
            MODE_RESET: begin
                if (!cfg.enabled) begin
                    rsp.completion = DONE_REJECTED;
                end else begin
                    rsp.bus_command = CMD_STOP;
                    n_wr_on         = 1'b0;
                    n_bytes_left    = 8'd0;
                    n_timeout       = 16'd0;
                    n_state         = ST_WAITING;
                end
            end
            default: ;
        endcase

        rsp.engine_state_out = n_state;
        rsp.write_irq_enable = n_wr_on;
    end

endmodule

### tb/testbench.sv
module testbench;
    import i2cmts_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 210;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    i2cmts_req_if req_ch ();
    i2cmts_rsp_if rsp_ch ();

    i2c_master_transfer_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the sequencer: configuration and transfer state
    logic        cfg_enabled  = 1'b0;
    logic [15:0] cfg_timeout  = TIMEOUT_RESET;
    t_state      xfer_state   = ST_WAITING;
    logic [7:0]  bytes_left   = 8'd0;
    logic [15:0] tick_budget  = 16'd0;
    logic        wirq_on      = 1'b0;

    t_rsp pending_results[$];
    t_rsp want_rsp;
    int   fail_count = 0;
    int   items_sent = 0;
    logic jitter_on  = 1'b1;
    int   hold_seq   = 0;
    int   hold_seen  = 0;
    int   stall_cnt  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic string rsp_text(input t_rsp v);
        return $sformatf("cmd=%0d byte=%02h took=%0b dv=%0b db=%02h done=%0d st=%0d wirq=%0b",
                         v.bus_command, v.bus_byte_out, v.tx_consumed, v.deliver_valid,
                         v.deliver_byte, v.completion, v.engine_state_out,
                         v.write_irq_enable);
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10)
            $display("%s", msg);
        fail_count++;
    endfunction

    // Advance the shadow state by one beat and return the result it should produce
    function automatic t_rsp next_bus_result(input t_req r);
        t_rsp o;
        logic busy;
        o = '0;
        busy = (xfer_state == ST_READING) || (xfer_state == ST_WRITING);
        case (r.mode)
            MODE_EVENT: begin
                // Error flags win over write-ready, which wins over byte-received
                if (r.arb_lost || r.bus_error || r.rx_nack) begin
                    wirq_on = 1'b0;
                    o.bus_command = CMD_STOP;
                    xfer_state = r.rx_nack ? ST_NACK : ST_ERROR;
                    if (busy)
                        o.completion = r.rx_nack ? DONE_NACK : DONE_ERROR;
                end else if (r.write_ready) begin
                    if (xfer_state == ST_WRITING) begin
                        if (bytes_left != 8'd0) begin
                            o.bus_command  = CMD_DATA;
                            o.bus_byte_out = r.tx_byte;
                            o.tx_consumed  = 1'b1;
                            bytes_left     = bytes_left - 8'd1;
                        end else begin
                            o.bus_command = CMD_STOP;
                            o.completion  = DONE_OK;
                            wirq_on       = 1'b0;
                            xfer_state    = ST_WAITING;
                        end
                    end
                end else if (r.read_ready) begin
                    if (xfer_state == ST_READING && bytes_left != 8'd0) begin
                        o.deliver_valid = 1'b1;
                        o.deliver_byte  = r.rx_byte_in;
                        bytes_left      = bytes_left - 8'd1;
                        if (bytes_left != 8'd0) begin
                            o.bus_command = CMD_ACK;
                        end else begin
                            o.bus_command = CMD_NACK_STOP;
                            o.completion  = DONE_OK;
                            xfer_state    = ST_WAITING;
                        end
                    end
                end
            end
            MODE_START_RD, MODE_START_WR: begin
                if (!cfg_enabled || busy ||
                    (r.mode == MODE_START_RD && r.transfer_length == 8'd0)) begin
                    o.completion = DONE_REJECTED;
                end else begin
                    bytes_left    = r.transfer_length;
                    tick_budget   = cfg_timeout;
                    o.bus_command = CMD_ADDR;
                    o.completion  = DONE_ACCEPTED;
                    if (r.mode == MODE_START_RD) begin
                        xfer_state     = ST_READING;
                        o.bus_byte_out = {r.target_address, RW_READ};
                    end else begin
                        xfer_state     = ST_WRITING;
                        o.bus_byte_out = {r.target_address, RW_WRITE};
                        wirq_on        = 1'b1;
                    end
                end
            end
            MODE_TICK: begin
                if (busy) begin
                    if (tick_budget <= 16'd1) begin
                        tick_budget  = 16'd0;
                        xfer_state   = ST_ERROR;
                        o.completion = DONE_ERROR;
                    end else begin
                        tick_budget = tick_budget - 16'd1;
                    end
                end
            end
            MODE_RESET: begin
                if (!cfg_enabled) begin
                    o.completion = DONE_REJECTED;
                end else begin
                    o.bus_command = CMD_STOP;
                    wirq_on       = 1'b0;
                    bytes_left    = 8'd0;
                    tick_budget   = 16'd0;
                    xfer_state    = ST_WAITING;
                end
            end
            default: ;
        endcase
        o.engine_state_out = xfer_state;
        o.write_irq_enable = wirq_on;
        return o;
    endfunction

    // Beat builders; fields a beat does not use are left random
    function automatic t_req rand_req();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return t_req'(bits[$bits(t_req)-1:0]);
    endfunction

    function automatic t_req plain_req(input logic [2:0] m);
        t_req r;
        r = rand_req();
        r.mode = m;
        return r;
    endfunction

    function automatic t_req start_req(input t_mode m, input logic [6:0] a,
                                       input logic [7:0] n);
        t_req r;
        r = rand_req();
        r.mode            = m;
        r.target_address  = a;
        r.transfer_length = n;
        return r;
    endfunction

    function automatic t_req bus_event(input logic arb, berr, nack, wr, rd,
                                       input logic [7:0] rx, tx);
        t_req r;
        r = rand_req();
        r.mode        = MODE_EVENT;
        r.arb_lost    = arb;
        r.bus_error   = berr;
        r.rx_nack     = nack;
        r.write_ready = wr;
        r.read_ready  = rd;
        r.rx_byte_in  = rx;
        r.tx_byte     = tx;
        return r;
    endfunction

    // Offer one beat, idling first at random, and record its expected result
    task automatic send_req(input t_req r);
        if (jitter_on) begin
            while ($urandom_range(0, 99) < 38) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_results.push_back(next_bus_result(r));
        items_sent++;
    endtask

    // Hold the input side until every expected result has come back
    task automatic wait_results_in();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write a register over APB, then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] want;
        wait_results_in();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_ENABLED) begin
            cfg_enabled = val[0];
            want = {31'd0, val[0]};
        end else begin
            cfg_timeout = val[15:0];
            want = {16'd0, val[15:0]};
        end
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want)
            note_failure($sformatf("register %0d read back %08h, expected %08h",
                                   idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Starts, a reset and a write-ready event while the controller is disabled
    task automatic test_disabled_rejects();
        send_req(start_req(MODE_START_RD, 7'h55, 8'd4));
        send_req(start_req(MODE_START_WR, 7'h2a, 8'd0));
        send_req(plain_req(MODE_RESET));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h11, 8'h22));
    endtask

    // Hand-picked sequences covering each code path and the field extremes
    task automatic test_directed_paths();
        int m;
        write_reg(REG_ENABLED, 32'd1);
        write_reg(REG_TIMEOUT, 32'd3);
        // zero-length read, then an error flag while idle
        send_req(start_req(MODE_START_RD, 7'h7f, 8'd0));
        send_req(bus_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        // zero-length write from the error state
        send_req(start_req(MODE_START_WR, 7'h7f, 8'd0));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'ha5));
        // two-byte read with a rejected start and a write-ready in between
        send_req(start_req(MODE_START_RD, 7'h7f, 8'd2));
        send_req(start_req(MODE_START_WR, 7'h01, 8'd3));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 8'h00));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h33, 8'hff));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'hff));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h5a, 8'h00));
        // long write, then run out the timeout with ticks
        send_req(start_req(MODE_START_WR, 7'h00, 8'hff));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hff));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'hff, 8'h00));
        repeat (4) send_req(plain_req(MODE_TICK));
        // read from the error state keeps write events on
        send_req(start_req(MODE_START_RD, 7'h40, 8'd1));
        send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h80, 8'h00));
        // nack during a write, then a bus error during a read from nack
        send_req(start_req(MODE_START_WR, 7'h2a, 8'd1));
        send_req(bus_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00));
        send_req(start_req(MODE_START_RD, 7'h15, 8'd1));
        send_req(bus_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
        // undefined modes, then a reset beat
        for (m = int'(MODE_RESET) + 1; m < 8; m++)
            send_req(plain_req(3'(m)));
        send_req(plain_req(MODE_RESET));
        write_reg(REG_TIMEOUT, 32'hffff);
    endtask

    // Consumer holds off while the producer keeps offering beats
    task automatic test_backpressure();
        int i;
        wait_results_in();
        hold_seq++;
        send_req(start_req(MODE_START_WR, 7'($urandom), 8'd40));
        for (i = 0; i < 30; i++)
            send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'($urandom), 8'($urandom)));
        wait_results_in();
    endtask

    // One transfer: a start and its events, with ticks, and sometimes noise or a break
    task automatic run_transfer();
        logic       rd_xfer;
        logic       messy;
        logic [7:0] len;
        logic [2:0] flags;
        int         n;
        int         i;
        int         p;
        rd_xfer = 1'($urandom_range(0, 1));
        messy   = ($urandom_range(0, 99) < 30);
        p = $urandom_range(0, 999);
        if (p < 800)
            len = 8'($urandom_range(0, 6));
        else if (p < 980)
            len = 8'($urandom_range(7, 40));
        else if (p < 995)
            len = 8'($urandom_range(41, 100));
        else
            len = 8'hff;
        n = rd_xfer ? int'(len) : int'(len) + 1;
        send_req(start_req(rd_xfer ? MODE_START_RD : MODE_START_WR, 7'($urandom), len));
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15)
                send_req(plain_req(MODE_TICK));
            if (messy) begin
                p = $urandom_range(0, 99);
                if (p < 4) begin
                    send_req(rand_req());
                end else if (p < 6) begin
                    flags = 3'($urandom_range(1, 7));
                    send_req(bus_event(flags[2], flags[1], flags[0], 1'($urandom),
                                       1'($urandom), 8'($urandom), 8'($urandom)));
                    break;
                end else if (p < 7) begin
                    send_req(plain_req(MODE_RESET));
                    break;
                end else if (p < 9) begin
                    send_req(start_req($urandom_range(0, 1) ? MODE_START_RD : MODE_START_WR,
                                       7'($urandom), 8'($urandom)));
                end
            end
            if (rd_xfer)
                send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom), 8'($urandom)));
            else
                send_req(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom), 8'($urandom),
                                   8'($urandom)));
        end
    endtask

    // Random transfers over several timeout and enable settings
    task automatic test_random_traffic();
        int          phase;
        int          stop_at;
        logic [15:0] tmo;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       tmo = 16'd1;
                1:       tmo = 16'hffff;
                2:       tmo = TIMEOUT_RESET;
                default: tmo = 16'($urandom_range(2, 24));
            endcase
            write_reg(REG_TIMEOUT, {16'd0, tmo});
            write_reg(REG_ENABLED, {31'd0, phase != 5});
            jitter_on = (phase != 3);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 99) < 3)
                    wait_results_in();
                run_transfer();
            end
        end
        jitter_on = 1'b1;
    endtask

    // Result consumer: random stalls plus long hold-offs on request
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                stall_cnt = HOLD_CYCLES;
            end
            if (stall_cnt != 0) begin
                stall_cnt--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= !jitter_on || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", rsp_text(rsp_ch.data)));
            end else begin
                want_rsp = pending_results.pop_front();
                if (rsp_ch.data !== want_rsp)
                    note_failure($sformatf("mismatch: expected %s, got %s",
                                           rsp_text(want_rsp), rsp_text(rsp_ch.data)));
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled_rejects();
        test_directed_paths();
        test_backpressure();
        test_random_traffic();

        wait_results_in();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
